// ----- hdl/bls_pkg.sv -----
// Shared types and constants for the bounded list store.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bls_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_SEARCH = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  // Which index the memory read port looks up.
  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_POS  = 2'd1,
    RD_NEXT = 2'd2
  } rd_src_e;

  // Which result the datapath captures.
  typedef enum logic [1:0] {
    RSP_EXEC = 2'd0,
    RSP_READ = 2'd1,
    RSP_HIT  = 2'd2,
    RSP_MISS = 2'd3
  } rsp_sel_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] key_value;
    logic [3:0]         position;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         found_position;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    logic               is_empty;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic     load;
    logic     exec;
    logic     rd_en;
    rd_src_e  rd_src;
    logic     scan_step;
    logic     respond;
    rsp_sel_e rsp_sel;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic op_read;
    logic op_search;
    logic pos_ok;
    logic occ_zero;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

// ----- hdl/bounded_list_store_top.sv -----
// Top level of the bounded list store: controller plus datapath.
// Depends on bls_pkg, bls_ctrl and bls_dp.
`timescale 1ns / 1ps

// Bounded list store: a ring of DEPTH signed keys with push at the head,
// pop at the tail, search, indexed read/write and clear.
//
// Request channel: drive req_i and raise start; the request is taken at
// the rising edge where start is high and busy is low. busy stays high
// while the request is in flight.
// Result channel: rsp_o is valid for exactly one cycle while done_o is
// high. The receiver cannot stall; every request yields one result.
//
// Sequence from acceptance to done_o:
//   push, pop, write, clear, unused codes, bad read index, empty search: executed
//           in the decode state; read at a valid index: decode, then the read state
//           (registered memory read); search: decode fetches the head entry, then the
//           scan state compares k entries, k at most the occupancy; the scan compares
//           one entry per cycle through the single memory read port.
// A new request is taken in the cycle done_o is high.
// Reset empties the store (count and head pointer to zero); the key
// memory itself is not cleared, since only held entries are ever read.

module bounded_list_store_top
  import bls_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output rsp_t rsp_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing: decode, read wait, one-entry-per-cycle scan
  bls_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // key memory, ring pointers and result register
  bls_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- hdl/bls_ctrl.sv -----
// Sequencing state machine for the bounded list store.
// Depends on bls_pkg (command and status structs).
`timescale 1ns / 1ps

module bls_ctrl
  import bls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy,
  output logic     done_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_READ   = 4'b0100,
    S_SCAN   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.rd_src    = RD_HEAD;
    cmd_o.rsp_sel   = RSP_EXEC;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.op_read && stat_i.pos_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_POS;
          state_d      = S_READ;
        end else if (stat_i.op_search && !stat_i.occ_zero) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_HEAD;
          state_d      = S_SCAN;
        end else begin
          cmd_o.exec    = 1'b1;
          cmd_o.respond = 1'b1;
          cmd_o.rsp_sel = RSP_EXEC;
          state_d       = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.respond = 1'b1;
        cmd_o.rsp_sel = RSP_READ;
        state_d       = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.respond = 1'b1;
          cmd_o.rsp_sel = RSP_HIT;
          state_d       = S_IDLE;
        end else if (stat_i.last) begin
          cmd_o.respond = 1'b1;
          cmd_o.rsp_sel = RSP_MISS;
          state_d       = S_IDLE;
        end else begin
          // no match yet: advance the index and fetch the next entry to compare
          cmd_o.scan_step = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_src    = RD_NEXT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.respond;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ----- hdl/bls_dp.sv -----
// Datapath of the bounded list store: key memory, ring pointers,
// scan index and result register. Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_dp
  import bls_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output rsp_t     rsp_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 4) ? CW : 4;
  localparam int XW = (KEY_BITS > 32) ? KEY_BITS : 32;

  logic [KEY_BITS-1:0] mem [DEPTH];

  op_e                 op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [3:0]          pos_q;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       occ_q, occ_d;
  logic [CW-1:0]       idx_q;
  logic [KEY_BITS-1:0] rdata_q;
  rsp_t                rsp_q;

  logic [XW-1:0]       key_in_ext;
  logic [XW-1:0]       key_out_ext;
  logic [AW-1:0]       head_m1;
  logic [AW-1:0]       pos_slot;
  logic [AW-1:0]       rd_addr;
  logic                we;
  logic [AW-1:0]       wa;
  status_e             exec_status;
  logic [CW:0]         idx_inc;

  // ring slot of an index counted from the head
  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] head, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(off);
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // 32-bit signed input key to stored key width
  assign key_in_ext  = XW'($signed(req_i.key_value));
  assign key_out_ext = XW'($signed(rdata_q));

  assign head_m1  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign pos_slot = slot_of(head_q, CW'(pos_q));
  assign idx_inc  = (CW + 1)'(idx_q) + 1'b1;

  always_comb begin
    unique case (cmd_i.rd_src)
      RD_POS:  rd_addr = pos_slot;
      RD_NEXT: rd_addr = slot_of(head_q, idx_inc[CW-1:0]);
      default: rd_addr = head_q;
    endcase
  end

  assign stat_o.op_read   = (op_q == OP_READ);
  assign stat_o.op_search = (op_q == OP_SEARCH);
  assign stat_o.pos_ok    = (PW'(pos_q) < PW'(occ_q));
  assign stat_o.occ_zero  = (occ_q == '0);
  assign stat_o.hit       = (rdata_q == key_q);
  assign stat_o.last      = (idx_inc == (CW + 1)'(occ_q));

  // operations completed by the exec command
  always_comb begin
    head_d      = head_q;
    occ_d       = occ_q;
    we          = 1'b0;
    wa          = head_m1;
    exec_status = ST_OK;
    if (cmd_i.exec) begin
      unique case (op_q)
        OP_PUSH: begin
          if (occ_q == CW'(DEPTH)) begin
            exec_status = ST_FULL;
          end else begin
            we     = 1'b1;
            wa     = head_m1;
            head_d = head_m1;
            occ_d  = occ_q + 1'b1;
          end
        end
        OP_POP: begin
          if (occ_q == '0) begin
            exec_status = ST_EMPTY;
          end else begin
            occ_d = occ_q - 1'b1;
          end
        end
        OP_SEARCH: exec_status = ST_NOT_FOUND;
        OP_READ:   exec_status = ST_RANGE;
        OP_WRITE: begin
          if (stat_o.pos_ok) begin
            we = 1'b1;
            wa = pos_slot;
          end else begin
            exec_status = ST_RANGE;
          end
        end
        OP_CLEAR: begin
          occ_d  = '0;
          head_d = '0;
        end
        default: exec_status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= key_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
    end else begin
      head_q <= head_d;
      occ_q  <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(req_i.operation);
      key_q <= key_in_ext[KEY_BITS-1:0];
      pos_q <= req_i.position;
      idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      rsp_q.found_position <= '0;
      rsp_q.read_value     <= '0;
      rsp_q.entry_count    <= 5'(occ_d);
      rsp_q.is_empty       <= (occ_d == '0);
      case (cmd_i.rsp_sel)
        RSP_READ: begin
          rsp_q.status     <= ST_OK;
          rsp_q.read_value <= key_out_ext[31:0];
        end
        RSP_HIT: begin
          rsp_q.status         <= ST_OK;
          rsp_q.found_position <= 4'(idx_q);
          rsp_q.read_value     <= key_out_ext[31:0];
        end
        RSP_MISS: rsp_q.status <= ST_NOT_FOUND;
        default:  rsp_q.status <= exec_status;
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule
